[sv/cpd_pkg.sv]
`default_nettype none

package cpd_pkg;

	// fixed field widths
	localparam int PX_W     = 16;
	localparam int SQ_OUT_W = 33;
	localparam int Q8_W     = 25;
	localparam int USED_W   = 9;

	// running minimum and square root widths
	localparam int BEST_W    = 34;
	localparam int FRAC_BITS = 16;
	localparam int RAD_W     = BEST_W + FRAC_BITS;
	localparam int ROOT_W    = RAD_W / 2;

	// defaults for the top level parameters
	localparam int DEF_MAX_POINTS = 256;
	localparam int DEF_COORD_BITS = 16;

	// one input item: a point
	typedef struct packed {
		logic signed [PX_W-1:0] px;
		logic signed [PX_W-1:0] py;
		logic                   last_point;
	} pt_t;

	// one result item
	typedef struct packed {
		logic [SQ_OUT_W-1:0] min_dist_sq;
		logic [Q8_W-1:0]     min_dist_q8;
		logic                no_pair;
		logic                dropped;
		logic [USED_W-1:0]   points_used;
	} res_t;

	// control sequence of the top level
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_SQRT,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

[sv/cpd_isqrt.sv]
`default_nettype none

module cpd_isqrt
	import cpd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [RAD_W-1:0]  radicand,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);

	localparam int RM_W  = ROOT_W + 1;
	localparam int SH_W  = RM_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [RM_W-1:0]   rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [SH_W-1:0]   rem_sh;
	logic [SH_W-1:0]   trial;
	logic [SH_W-1:0]   rem_sub;
	logic              ge;

	// one result bit per cycle, two radicand bits consumed
	always_comb begin
		rem_sh  = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial   = SH_W'({root_q, 2'b01});
		ge      = (rem_sh >= trial);
		rem_sub = rem_sh - trial;
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and partial root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? rem_sub[RM_W-1:0] : rem_sh[RM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

[sv/closest_pair_distance.sv]
// closest pair of 2-D points over a set of points
//
// pt channel: one point per item (px, py, last_point); the set closes with the
// item that has last_point high. res channel: one result item per set with the
// exact minimum squared distance, its floor square root in Q.8, no_pair,
// dropped and points_used.
// each accepted point is checked against every point already kept, one store
// read per cycle through a three-stage difference/square/compare pipeline, so
// pt_stall stays high after a point is accepted until that scan has drained;
// the closing point also waits for a bit-serial square root before the result
// is registered.
// points arriving with the store full are not compared and set dropped.
// the result sits in an output register: while res_stall holds it, the next
// set is already taken in; only a second finished result waits for the
// register to free.
// reset clears the set (count, running minimum, drop flag) and the output
// valid flag; the point store needs no clearing pass since only written
// entries are ever read.
`default_nettype none

module closest_pair_distance
	import cpd_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pt_valid,
	output logic      pt_stall,
	input  wire pt_t  pt,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int CB     = COORD_BITS;
	localparam int EXT_W  = (CB > PX_W) ? CB : PX_W;
	localparam int SQ_W   = 2 * CB;
	localparam int DW     = SQ_W + 1;
	localparam int CW     = (DW > BEST_W) ? DW : BEST_W;

	state_t state_q;
	state_t state_nx;

	logic             accept;
	logic             rd_en;
	logic             pipe_empty;
	logic             sq_start;
	logic             fin_load;

	logic [EXT_W-1:0] px_ext;
	logic [EXT_W-1:0] py_ext;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] lim_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [BEST_W-1:0] best_q;
	logic             ovf_q;
	logic [CB-1:0]    x_q;
	logic [CB-1:0]    y_q;
	logic             last_q;

	logic [2*CB-1:0]  mem [MAX_POINTS];
	logic [2*CB-1:0]  rd_data_s1;
	logic             v_s1;
	logic [CB-1:0]    ax_s2;
	logic [CB-1:0]    ay_s2;
	logic             v_s2;
	logic [SQ_W-1:0]  sqx_s3;
	logic [SQ_W-1:0]  sqy_s3;
	logic             v_s3;

	logic [CB:0]      dx;
	logic [CB:0]      dy;
	logic [CB:0]      dxn;
	logic [CB:0]      dyn;
	logic [DW-1:0]    d_sum;
	logic             no_pair;
	logic [BEST_W-1:0] sq_sel;
	logic             sq_done;
	logic [ROOT_W-1:0] sq_root;

	logic             res_valid_q;
	res_t             res_q;

	// coordinates: low COORD_BITS bits of the port
	assign px_ext = EXT_W'($unsigned(pt.px));
	assign py_ext = EXT_W'($unsigned(pt.py));

	assign accept     = pt_valid && !pt_stall;
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign no_pair    = (cnt_q < CNT_W'(2));
	assign sq_sel     = no_pair ? '0 : best_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and control
	always_comb begin
		state_nx = state_q;
		pt_stall = 1'b1;
		rd_en    = 1'b0;
		sq_start = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pt_stall = 1'b0;
				if (pt_valid) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_idx_q < lim_q) begin
					rd_en = 1'b1;
				end else begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_empty) begin
					if (last_q) begin
						sq_start = 1'b1;
						state_nx = ST_SQRT;
					end else begin
						state_nx = ST_IDLE;
					end
				end
			end
			ST_SQRT: begin
				if (sq_done) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!res_valid_q || !res_stall) begin
					fin_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// set bookkeeping: count, scan limit, running minimum, drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			lim_q    <= '0;
			rd_idx_q <= '0;
			best_q   <= '1;
			ovf_q    <= 1'b0;
		end else begin
			if (accept) begin
				rd_idx_q <= '0;
				if (cnt_q < CNT_W'(MAX_POINTS)) begin
					lim_q <= cnt_q;
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					lim_q <= '0;
					ovf_q <= 1'b1;
				end
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (v_s3 && (CW'(d_sum) < CW'(best_q))) begin
				best_q <= BEST_W'(d_sum);
			end
			if (fin_load) begin
				cnt_q  <= '0;
				best_q <= '1;
				ovf_q  <= 1'b0;
			end
		end
	end

	// incoming point
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= px_ext[CB-1:0];
			y_q    <= py_ext[CB-1:0];
			last_q <= pt.last_point;
		end
	end

	// point store: new point written at accept, older points read during scan
	always_ff @(posedge clk) begin
		if (accept && (cnt_q < CNT_W'(MAX_POINTS))) begin
			mem[cnt_q[ADDR_W-1:0]] <= {px_ext[CB-1:0], py_ext[CB-1:0]};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// coordinate differences, sign-extended from COORD_BITS
	always_comb begin
		dx    = {x_q[CB-1], x_q} - {rd_data_s1[2*CB-1], rd_data_s1[2*CB-1:CB]};
		dy    = {y_q[CB-1], y_q} - {rd_data_s1[CB-1], rd_data_s1[CB-1:0]};
		dxn   = -dx;
		dyn   = -dy;
		d_sum = DW'(sqx_s3) + DW'(sqy_s3);
	end

	// absolute differences, then squares
	always_ff @(posedge clk) begin
		ax_s2  <= dx[CB] ? dxn[CB-1:0] : dx[CB-1:0];
		ay_s2  <= dy[CB] ? dyn[CB-1:0] : dy[CB-1:0];
		sqx_s3 <= ax_s2 * ax_s2;
		sqy_s3 <= ay_s2 * ay_s2;
	end

	// square root of the minimum with sixteen extra fraction bits
	cpd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({sq_sel, {FRAC_BITS{1'b0}}}),
		.done     (sq_done),
		.root     (sq_root)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			res_q.min_dist_sq <= sq_sel[SQ_OUT_W-1:0];
			res_q.min_dist_q8 <= Q8_W'(sq_root);
			res_q.no_pair     <= no_pair;
			res_q.dropped     <= ovf_q;
			res_q.points_used <= USED_W'(cnt_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// kept points never exceed the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	// a new point only enters with the compare pipeline empty
	a_accept_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> pipe_empty)
		else $error("point accepted while compare pipeline busy");

	// square root finishes only while the sequencer waits for it
	a_sqrt_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == ST_SQRT))
		else $error("square root done outside its wait state");

	// a loaded result with no pair carries zero distance
	a_no_pair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> (!res_q.no_pair ||
			(res_q.min_dist_sq == '0 && res_q.min_dist_q8 == '0)))
		else $error("no-pair result with nonzero distance");
`endif

endmodule

`default_nettype wire

[dv/closest_pair_checker.sv]
`timescale 1ns / 1ps

module closest_pair_checker
	import cpd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pt_valid,
	input  wire logic pt_stall,
	input  wire pt_t  pt,
	input  wire logic res_valid,
	input  wire logic res_stall,
	input  wire res_t res,
	output int        fails,
	output int        outstanding
);

	localparam int PT_CAP = DEF_MAX_POINTS;
	localparam int CRD_W  = DEF_COORD_BITS;

	// points kept for the set being collected
	longint            kept_x [PT_CAP];
	longint            kept_y [PT_CAP];
	int                kept_n;
	logic [BEST_W-1:0] run_best;
	logic              spill;

	// one predicted result per closed set, oldest first
	res_t pending_minima [$];
	res_t oldest;
	int   fail_count;

	// sign-extend the low coordinate bits
	function automatic longint widen(logic [PX_W-1:0] v);
		longint r;
		r = longint'(v) & ((longint'(1) << CRD_W) - 1);
		if (r[CRD_W-1])
			r = r - (longint'(1) << CRD_W);
		return r;
	endfunction

	// floor(sqrt(sq) * 256), built one result bit at a time
	function automatic logic [Q8_W-1:0] root_q8(logic [SQ_OUT_W-1:0] sq);
		logic [63:0] rad;
		logic [63:0] guess;
		logic [63:0] trial;
		rad   = 64'(sq) << FRAC_BITS;
		guess = '0;
		for (int b = Q8_W - 1; b >= 0; b--) begin
			trial = guess | (64'd1 << b);
			if (trial * trial <= rad)
				guess = trial;
		end
		return guess[Q8_W-1:0];
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic open_set();
		kept_n   = 0;
		run_best = '1;
		spill    = 1'b0;
	endtask

	// compare a new point with every kept one unless the store is full, close the set on the last point
	task automatic fold_point(pt_t p);
		longint x;
		longint y;
		longint dx;
		longint dy;
		longint d;
		res_t   r;
		x = widen(p.px);
		y = widen(p.py);
		if (kept_n < PT_CAP) begin
			for (int i = 0; i < kept_n; i++) begin
				dx = x - kept_x[i];
				dy = y - kept_y[i];
				d  = dx * dx + dy * dy;
				if (d < longint'(run_best))
					run_best = d[BEST_W-1:0];
			end
			kept_x[kept_n] = x;
			kept_y[kept_n] = y;
			kept_n++;
		end else begin
			spill = 1'b1;
		end
		if (p.last_point) begin
			r.no_pair     = (kept_n < 2);
			r.min_dist_sq = r.no_pair ? '0 : run_best[SQ_OUT_W-1:0];
			r.min_dist_q8 = r.no_pair ? '0 : root_q8(run_best[SQ_OUT_W-1:0]);
			r.dropped     = spill;
			r.points_used = kept_n[USED_W-1:0];
			pending_minima = {pending_minima, r};
			open_set();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_set();
			pending_minima.delete();
			fail_count = 0;
			fails       <= 0;
			outstanding <= 0;
		end else begin
			// result item against the oldest prediction
			if (res_valid && !res_stall) begin
				if (pending_minima.size() == 0) begin
					report_mismatch("unexpected result, min_dist_sq", res.min_dist_sq, 0);
				end else begin
					oldest = pending_minima.pop_front();
					if (res.min_dist_sq !== oldest.min_dist_sq)
						report_mismatch("min_dist_sq", res.min_dist_sq, oldest.min_dist_sq);
					if (res.min_dist_q8 !== oldest.min_dist_q8)
						report_mismatch("min_dist_q8", res.min_dist_q8, oldest.min_dist_q8);
					if (res.no_pair !== oldest.no_pair)
						report_mismatch("no_pair", res.no_pair, oldest.no_pair);
					if (res.dropped !== oldest.dropped)
						report_mismatch("dropped", res.dropped, oldest.dropped);
					if (res.points_used !== oldest.points_used)
						report_mismatch("points_used", res.points_used, oldest.points_used);
				end
			end
			// point item into the predictor
			if (pt_valid && !pt_stall)
				fold_point(pt);
			fails       <= fail_count;
			outstanding <= pending_minima.size();
		end
	end

endmodule

[dv/closest_pair_distance_test.sv]
`timescale 1ns / 1ps

module closest_pair_distance_test;
	import cpd_pkg::*;

	localparam int RANDOM_ITEMS = 1350;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 300;

	typedef enum int {
		SPREAD_WIDE,
		SPREAD_CLUSTER,
		SPREAD_EDGE,
		SPREAD_REPEAT
	} spread_e;

	logic clk = 1'b0;
	logic arst_n;
	logic pt_valid;
	logic pt_stall;
	pt_t  pt;
	logic res_valid;
	logic res_stall;
	res_t res;

	logic steady = 1'b0;
	int   fails;
	int   outstanding;
	int   quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	closest_pair_distance uut (
		.clk,
		.arst_n,
		.pt_valid,
		.pt_stall,
		.pt,
		.res_valid,
		.res_stall,
		.res
	);

	closest_pair_checker minima_check (
		.clk,
		.arst_n,
		.pt_valid,
		.pt_stall,
		.pt,
		.res_valid,
		.res_stall,
		.res,
		.fails,
		.outstanding
	);

	// idle cycles before the next item, none during a steady stretch
	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic logic [PX_W-1:0] rim_coord();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	// one point item, held until accepted
	task automatic send_point(logic [PX_W-1:0] x, logic [PX_W-1:0] y, logic last);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			pt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt.px         <= x;
		pt.py         <= y;
		pt.last_point <= last;
		pt_valid      <= 1'b1;
		do @(posedge clk); while (pt_stall);
	endtask

	// a whole set of n points, last one marked
	task automatic send_set(int n, spread_e spread);
		logic [PX_W-1:0] bx;
		logic [PX_W-1:0] by;
		logic [PX_W-1:0] x;
		logic [PX_W-1:0] y;
		logic [PX_W-1:0] lx;
		logic [PX_W-1:0] ly;
		bx = 16'($urandom);
		by = 16'($urandom);
		lx = bx;
		ly = by;
		for (int i = 0; i < n; i++) begin
			case (spread)
				SPREAD_WIDE: begin
					x = 16'($urandom);
					y = 16'($urandom);
				end
				SPREAD_CLUSTER: begin
					x = bx + 16'($urandom_range(0, 31)) - 16'd16;
					y = by + 16'($urandom_range(0, 31)) - 16'd16;
				end
				SPREAD_EDGE: begin
					x = rim_coord();
					y = rim_coord();
				end
				default: begin
					if ($urandom_range(0, 2) == 0) begin
						x = lx;
						y = ly;
					end else begin
						x = bx + 16'($urandom_range(0, 7));
						y = by + 16'($urandom_range(0, 7));
					end
				end
			endcase
			lx = x;
			ly = y;
			send_point(x, y, i == n - 1);
		end
	endtask

	// result side stalls at random
	initial begin
		int w;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			w = draw_wait();
			if (w > 0) begin
				res_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	// watchdog on cycles with no item accepted
	always @(posedge clk) begin
		if (!arst_n || (pt_valid && !pt_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus and verdict
	initial begin
		int sent;
		int set_no;
		int n;
		arst_n    <= 1'b0;
		pt_valid  <= 1'b0;
		pt        <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single point, no pair
		send_point(16'h0000, 16'h0000, 1'b1);
		// opposite corners, largest distance
		send_point(16'h8000, 16'h8000, 1'b0);
		send_point(16'h7FFF, 16'h7FFF, 1'b1);
		// duplicate points, zero distance
		send_point(16'h0005, 16'hFFF9, 1'b0);
		send_point(16'h0005, 16'hFFF9, 1'b1);
		// other diagonal plus origin
		send_point(16'h7FFF, 16'h8000, 1'b0);
		send_point(16'h8000, 16'h7FFF, 1'b0);
		send_point(16'h0000, 16'h0000, 1'b1);
		// unit, 3-4-5 and root-two distances
		send_point(16'h0001, 16'h0000, 1'b0);
		send_point(16'h0000, 16'h0000, 1'b1);
		send_point(16'h0003, 16'h0004, 1'b0);
		send_point(16'h0000, 16'h0000, 1'b1);
		send_point(16'h0001, 16'h0001, 1'b0);
		send_point(16'h0000, 16'h0000, 1'b1);
		// mixed signs and axis extremes
		send_point(16'hFFFF, 16'hFFFF, 1'b0);
		send_point(16'h0002, 16'h0003, 1'b0);
		send_point(16'h0064, 16'hFF9C, 1'b0);
		send_point(16'h8000, 16'h0000, 1'b0);
		send_point(16'h7FFF, 16'h0000, 1'b1);
		// all four corners
		send_point(16'h7FFF, 16'h7FFF, 1'b0);
		send_point(16'h8000, 16'h8000, 1'b0);
		send_point(16'h7FFF, 16'h8000, 1'b0);
		send_point(16'h8000, 16'h7FFF, 1'b1);

		// random sets, two of them at or past capacity
		sent   = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 5) == 0);
			if (set_no == 3)
				n = DEF_MAX_POINTS;
			else if (set_no == 30)
				n = DEF_MAX_POINTS + 1 + $urandom_range(0, 7);
			else if ($urandom_range(0, 6) == 0)
				n = 1;
			else if ($urandom_range(0, 9) == 0)
				n = $urandom_range(13, 40);
			else
				n = $urandom_range(2, 12);
			send_set(n, spread_e'($urandom_range(0, 3)));
			sent += n;
			set_no++;
		end
		pt_valid <= 1'b0;

		// drain the remaining results
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
